>>> hdl/gge_pkg.sv
`default_nettype none
package gge_pkg;
  localparam int POP_SIZE_DEF   = 32;
  localparam int GENE_COUNT_DEF = 20;
  localparam logic [7:0] TARGET_RESET = 8'd50;
  localparam logic [5:0] ELITE_RESET  = 6'd3;
  localparam logic [2:0] MODE_LOAD = 3'd0;
  localparam logic [2:0] MODE_EVAL = 3'd1;
  localparam logic [2:0] MODE_BREED = 3'd2;
  localparam logic [2:0] MODE_ADV = 3'd3;
  localparam logic [2:0] MODE_READ = 3'd4;
  localparam logic CFG_TARGET = 1'b0;
  localparam logic CFG_ELITE  = 1'b1;

  // controller -> datapath commands
  typedef struct packed {
    logic clr;        // clear accumulators / start item
    logic src_rd;     // issue gene read from current bank
    logic acc;        // accumulate returned gene into sum
    logic fit_wr;     // store fitness of current chromosome
    logic wr_next;    // write returned gene into next bank
    logic wr_cur;     // load gene into current bank
    logic swap;       // flip banks and reset ranks
    logic rank_init;  // ranks to identity
    logic sort_step;  // one compare-swap of the sort sweep
    logic done;       // latch the result
  } gge_cmd_t;

  typedef struct packed {
    logic last_gene;
    logic last_indiv;
    logic sort_done;
    logic reject;
  } gge_sts_t;
endpackage
`default_nettype wire

>>> hdl/gge_ram.sv
`default_nettype none
module gge_ram #(
  parameter int WIDTH = 4,
  parameter int DEPTH = 1280
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

>>> hdl/gge_ctrl.sv
`default_nettype none
module gge_ctrl (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_stall,
  output logic                     out_valid,
  input  wire logic                out_stall,
  input  wire logic [2:0]          mode,
  output gge_pkg::gge_cmd_t        cmd,
  input  wire gge_pkg::gge_sts_t   sts
);
  import gge_pkg::*;
  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_EVRD  = 4'd1;
  localparam logic [3:0] S_EVWT  = 4'd2;
  localparam logic [3:0] S_EVACC = 4'd3;
  localparam logic [3:0] S_SORT  = 4'd4;
  localparam logic [3:0] S_CPRD  = 4'd5;
  localparam logic [3:0] S_CPWT  = 4'd6;
  localparam logic [3:0] S_CPWR  = 4'd7;
  localparam logic [3:0] S_RDWT  = 4'd8;
  localparam logic [3:0] S_FIN   = 4'd9;

  logic [3:0] state, state_next;
  logic [2:0] mode_r;
  logic       accept;
  assign accept = in_valid && !in_stall;
  // one item in flight; output register holds until taken
  assign in_stall = (state != S_IDLE) || out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
      mode_r <= MODE_LOAD;
    end else begin
      state <= state_next;
      if (accept) mode_r <= mode;
      if (cmd.done) out_valid <= 1'b1;
      else if (out_valid && !out_stall) out_valid <= 1'b0;
    end
  end

  always_comb begin
    cmd = '0;
    state_next = state;
    case (state)
      S_IDLE: if (accept) begin
        cmd.clr = 1'b1;
        case (mode)
          MODE_LOAD: begin
            cmd.wr_cur = 1'b1;
            cmd.done = 1'b1;
          end
          MODE_READ: begin
            cmd.src_rd = 1'b1;
            state_next = S_RDWT;
          end
          MODE_EVAL: state_next = S_EVRD;
          MODE_BREED: state_next = sts.reject ? S_FIN : S_CPRD;
          MODE_ADV: state_next = S_CPRD;
          default: cmd.done = 1'b1;
        endcase
      end
      // gene read at accept is on the RAM output now
      S_RDWT: begin
        cmd.done = 1'b1;
        state_next = S_IDLE;
      end
      S_EVRD: begin
        cmd.src_rd = 1'b1;
        state_next = S_EVWT;
      end
      S_EVWT: state_next = S_EVACC;
      S_EVACC: begin
        cmd.acc = 1'b1;
        if (sts.last_gene) begin
          cmd.fit_wr = 1'b1;
          if (sts.last_indiv) begin
            cmd.rank_init = 1'b1;
            state_next = S_SORT;
          end else begin
            state_next = S_EVRD;
          end
        end else begin
          state_next = S_EVRD;
        end
      end
      S_SORT: begin
        cmd.sort_step = 1'b1;
        if (sts.sort_done) state_next = S_FIN;
      end
      S_CPRD: begin
        if (sts.last_indiv) begin
          // nothing (left) to copy
          if (mode_r == MODE_ADV) cmd.swap = 1'b1;
          state_next = S_FIN;
        end else begin
          cmd.src_rd = 1'b1;
          state_next = S_CPWT;
        end
      end
      S_CPWT: state_next = S_CPWR;
      S_CPWR: begin
        cmd.wr_next = 1'b1;
        state_next = S_CPRD;
      end
      S_FIN: begin
        cmd.done = 1'b1;
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end
endmodule
`default_nettype wire

>>> hdl/gge_dp.sv
`default_nettype none
module gge_dp #(
  parameter int POP_SIZE   = gge_pkg::POP_SIZE_DEF,
  parameter int GENE_COUNT = gge_pkg::GENE_COUNT_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              cfg_valid,
  input  wire logic              cfg_index,
  input  wire logic [7:0]        cfg_data,
  input  wire logic              accept,
  input  wire logic [2:0]        mode,
  input  wire logic [4:0]        slot,
  input  wire logic [4:0]        position,
  input  wire logic signed [3:0] gene_value,
  input  wire logic [3:0]        parent_a,
  input  wire logic [3:0]        parent_b,
  input  wire logic [4:0]        cut_point,
  input  wire logic              do_mutate,
  input  wire logic [4:0]        mutate_position,
  input  wire logic signed [3:0] mutate_value,
  input  wire gge_pkg::gge_cmd_t cmd,
  output gge_pkg::gge_sts_t      sts,
  output logic signed [3:0]      read_value,
  output logic [7:0]             best_fitness,
  output logic                   solved,
  output logic                   status
);
  import gge_pkg::*;
  localparam int IW = $clog2(POP_SIZE);
  localparam int GW = $clog2(GENE_COUNT);
  localparam int BANK = POP_SIZE * GENE_COUNT;
  localparam int DEPTH = 2 * BANK;
  localparam int AW = $clog2(DEPTH);
  localparam int SW = $clog2(GENE_COUNT * 8 + 256) + 1;

  logic signed [7:0] target_sum;
  logic [5:0]        elite_count;
  logic              bank_select;
  logic [IW-1:0]     rank_table [POP_SIZE];
  logic [7:0]        fitness_table [POP_SIZE];

  // item registers
  logic [2:0]    mode_r;
  logic [IW:0]   slot_r;
  logic [4:0]    cut_r, mpos_r;
  logic [IW-1:0] pa_r, pb_r;
  logic          mut_r;
  logic [3:0]    mval_r;
  logic          rej_r;

  logic [IW:0]   indiv;     // chromosome index / elite index
  logic [GW:0]   gene;      // gene being read, held until its data is used
  logic [GW:0]   gene_d;    // gene whose data returns
  logic [GW:0]   gene_dd;
  logic signed [SW-1:0] sum;
  logic [IW:0]   elites;
  logic [IW:0]   sort_i, sort_j;

  always_comb begin
    if (elite_count > 6'(POP_SIZE)) elites = (IW+1)'(POP_SIZE);
    else elites = (IW+1)'(elite_count);
  end

  // rejection check on live inputs
  logic in_rej;
  logic [IW:0] slot_w;
  assign slot_w = (IW+1)'(slot);
  always_comb begin
    case (mode)
      MODE_LOAD, MODE_READ:
        in_rej = (32'(slot) >= POP_SIZE) || (32'(position) >= GENE_COUNT);
      MODE_EVAL, MODE_ADV: in_rej = 1'b0;
      MODE_BREED:
        in_rej = (32'(slot) >= POP_SIZE) || (slot_w < elites) ||
                 (32'(parent_a) >= POP_SIZE / 2) || (32'(parent_b) >= POP_SIZE / 2);
      default: in_rej = 1'b1;
    endcase
  end

  // memory
  logic          we;
  logic [AW-1:0] waddr, raddr;
  logic [3:0]    wdata, rdata;
  gge_ram #(.WIDTH(4), .DEPTH(DEPTH)) u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  function automatic logic [AW-1:0] addr_of(input logic bank, input logic [IW-1:0] ind,
                                            input logic [GW:0] g);
    logic [AW:0] a;
    begin
      a = (AW+1)'(bank) * (AW+1)'(BANK) + (AW+1)'(ind) * (AW+1)'(GENE_COUNT) + (AW+1)'(g);
      addr_of = a[AW-1:0];
    end
  endfunction

  logic [IW-1:0] live_phys;
  assign live_phys = rank_table[slot[IW-1:0]];

  // read source
  logic [IW-1:0] src_ind;
  logic [IW-1:0] copy_dst;
  logic [GW:0]   gidx;
  always_comb begin
    gidx = cmd.clr ? (GW+1)'(position) : gene;
    if (cmd.clr) src_ind = live_phys;
    else if (mode_r == MODE_EVAL) src_ind = indiv[IW-1:0];
    else if (mode_r == MODE_ADV) src_ind = rank_table[indiv[IW-1:0]];
    else if ((GW+1)'(gene) < (GW+1)'(cut_r) || 32'(cut_r) >= GENE_COUNT)
      src_ind = rank_table[pa_r];
    else src_ind = rank_table[pb_r];
    raddr = addr_of(bank_select, src_ind, gidx);
  end
  assign copy_dst = (mode_r == MODE_ADV) ? indiv[IW-1:0] : slot_r[IW-1:0];

  always_comb begin
    we = 1'b0;
    waddr = addr_of(bank_select, live_phys, (GW+1)'(position));
    wdata = gene_value;
    if (cmd.wr_cur && !in_rej) we = 1'b1;
    else if (cmd.wr_next) begin
      we = 1'b1;
      waddr = addr_of(!bank_select, copy_dst, gene_dd);
      wdata = (mode_r == MODE_BREED && mut_r && (GW+1)'(mpos_r) == gene_dd &&
               32'(mpos_r) < GENE_COUNT) ? mval_r : rdata;
    end
  end

  // status
  assign sts.reject = in_rej;
  assign sts.last_gene = 32'(gene_dd) == GENE_COUNT - 1;
  assign sts.last_indiv = (mode_r == MODE_EVAL) ? (32'(indiv) == POP_SIZE - 1) :
                          (mode_r == MODE_ADV) ? (indiv >= elites) : (indiv != '0);
  assign sts.sort_done = (32'(sort_i) >= POP_SIZE - 1) && (sort_j == '0);

  // insertion sort as adjacent compare-swap, one step a cycle
  logic swap_now;
  assign swap_now = sort_j != '0 &&
    fitness_table[rank_table[sort_j[IW-1:0] - 1'b1]] > fitness_table[rank_table[sort_j[IW-1:0]]];

  logic signed [SW-1:0] sum_new, diff;
  logic [SW-1:0] adiff;
  assign sum_new = sum + SW'($signed(rdata));
  assign diff = sum_new - SW'(target_sum);
  assign adiff = diff[SW-1] ? SW'(-diff) : SW'(diff);

  always_ff @(posedge clk) begin
    if (rst) begin
      target_sum <= TARGET_RESET;
      elite_count <= ELITE_RESET;
      bank_select <= 1'b0;
      for (int k = 0; k < POP_SIZE; k++) rank_table[k] <= IW'(k);
      mode_r <= MODE_LOAD;
    end else begin
      if (cfg_valid) begin
        if (cfg_index == CFG_TARGET) target_sum <= cfg_data;
        else elite_count <= cfg_data[5:0];
      end
      if (accept) begin
        mode_r <= mode;
        slot_r <= (IW+1)'(slot);
        cut_r <= cut_point;
        pa_r <= IW'(parent_a);
        pb_r <= IW'(parent_b);
        mut_r <= do_mutate;
        mpos_r <= mutate_position;
        mval_r <= mutate_value;
        rej_r <= in_rej;
        indiv <= '0;
        gene <= '0;
        sum <= '0;
      end
      gene_d <= gene;
      gene_dd <= gene_d;
      // address stays put until the returned gene is consumed
      if (cmd.acc || cmd.wr_next) gene <= (32'(gene) == GENE_COUNT - 1) ? '0 : gene + 1'b1;
      if (cmd.acc) begin
        sum <= sts.last_gene ? '0 : sum_new;
        if (sts.last_gene) indiv <= indiv + 1'b1;
      end
      if (cmd.fit_wr)
        fitness_table[indiv[IW-1:0]] <= (adiff > SW'(255)) ? 8'd255 : adiff[7:0];
      if (cmd.wr_next) begin
        if (sts.last_gene) indiv <= indiv + 1'b1;
      end
      if (cmd.rank_init) begin
        for (int k = 0; k < POP_SIZE; k++) rank_table[k] <= IW'(k);
        sort_i <= (IW+1)'(1);
        sort_j <= (IW+1)'(1);
      end
      if (cmd.sort_step) begin
        if (swap_now) begin
          rank_table[sort_j[IW-1:0]] <= rank_table[sort_j[IW-1:0] - 1'b1];
          rank_table[sort_j[IW-1:0] - 1'b1] <= rank_table[sort_j[IW-1:0]];
          sort_j <= sort_j - 1'b1;
        end else if (32'(sort_i) < POP_SIZE - 1) begin
          sort_i <= sort_i + 1'b1;
          sort_j <= sort_i + 1'b1;
        end else begin
          sort_j <= '0;
        end
      end
      if (cmd.swap) begin
        bank_select <= !bank_select;
        for (int k = 0; k < POP_SIZE; k++) rank_table[k] <= IW'(k);
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.done) begin
      status <= cmd.clr ? in_rej : rej_r;
      read_value <= (!cmd.clr && mode_r == MODE_READ && !rej_r) ? rdata : '0;
      best_fitness <= (!cmd.clr && mode_r == MODE_EVAL) ? fitness_table[rank_table[0]] : '0;
      solved <= !cmd.clr && mode_r == MODE_EVAL && fitness_table[rank_table[0]] == 8'd0;
    end
  end
endmodule
`default_nettype wire

>>> hdl/genetic_generation_engine.sv
`default_nettype none
// Genetic-algorithm generation engine: 32 chromosomes of 20 signed 4-bit genes in
// two banks of one gene RAM (current and next). One item in flight at a time; a
// result is held in the output register until taken. Load and an unknown mode finish
// in the accepting state, read passes through RDWT and a rejected breed through FIN;
// evaluate reads every gene through the RAM port (states EVRD, EVWT, EVACC per gene)
// then ranks by an adjacent compare-swap sort, one step a cycle; breed copies 20
// genes through states CPRD, CPWT, CPWR each, advance copies elite_count chromosomes
// (capped at POP_SIZE) the same way, all through the single RAM read port.
module genetic_generation_engine #(
  parameter int POP_SIZE   = gge_pkg::POP_SIZE_DEF,
  parameter int GENE_COUNT = gge_pkg::GENE_COUNT_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic [2:0]        mode,
  input  wire logic [4:0]        slot,
  input  wire logic [4:0]        position,
  input  wire logic signed [3:0] gene_value,
  input  wire logic [3:0]        parent_a,
  input  wire logic [3:0]        parent_b,
  input  wire logic [4:0]        cut_point,
  input  wire logic              do_mutate,
  input  wire logic [4:0]        mutate_position,
  input  wire logic signed [3:0] mutate_value,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic signed [3:0]      read_value,
  output logic [7:0]             best_fitness,
  output logic                   solved,
  output logic                   status,
  input  wire logic              cfg_valid,
  output logic                   cfg_ready,
  input  wire logic              cfg_index,
  input  wire logic [7:0]        cfg_data
);
  import gge_pkg::*;
  gge_cmd_t cmd;
  gge_sts_t sts;
  assign cfg_ready = 1'b1;

  gge_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .out_valid(out_valid), .out_stall(out_stall), .mode(mode), .cmd(cmd), .sts(sts)
  );

  gge_dp #(.POP_SIZE(POP_SIZE), .GENE_COUNT(GENE_COUNT)) u_dp (
    .clk(clk), .rst(rst), .cfg_valid(cfg_valid), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .accept(in_valid && !in_stall), .mode(mode), .slot(slot),
    .position(position), .gene_value(gene_value), .parent_a(parent_a),
    .parent_b(parent_b), .cut_point(cut_point), .do_mutate(do_mutate),
    .mutate_position(mutate_position), .mutate_value(mutate_value), .cmd(cmd),
    .sts(sts), .read_value(read_value), .best_fitness(best_fitness),
    .solved(solved), .status(status)
  );
endmodule
`default_nettype wire

>>> hdl/gge_checker.sv
`default_nettype none
module gge_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       in_valid,
  input wire logic       in_stall,
  input wire logic       out_valid,
  input wire logic       out_stall,
  input wire logic [3:0] read_value,
  input wire logic [7:0] best_fitness,
  input wire logic       solved,
  input wire logic       status
);
  // a result is never replaced while stalled
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(best_fitness) && $stable(status))
    else $error("result changed while stalled");
  // no new item while a result waits
  a_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall) else $error("item taken with result pending");
  a_solved: assert property (@(posedge clk) disable iff (rst)
    out_valid && solved |-> best_fitness == 8'd0) else $error("solved with nonzero fitness");
  a_rej: assert property (@(posedge clk) disable iff (rst)
    out_valid && status |-> read_value == 4'd0 && !solved) else $error("rejected with data");
endmodule

bind genetic_generation_engine gge_checker u_chk (
  .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
  .out_valid(out_valid), .out_stall(out_stall), .read_value(read_value),
  .best_fitness(best_fitness), .solved(solved), .status(status)
);
`default_nettype wire
